/* rtl/core/ebalu_pkg.sv */
package ebalu_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned OP_W   = 4;

  // Status byte bit positions.
  localparam int unsigned FLAG_C_BIT = 0;
  localparam int unsigned FLAG_Z_BIT = 1;
  localparam int unsigned FLAG_V_BIT = 6;
  localparam int unsigned FLAG_N_BIT = 7;
  localparam int unsigned SIGN_BIT   = DATA_W - 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 4'd0,
    OP_AND  = 4'd1,
    OP_OR   = 4'd2,
    OP_XOR  = 4'd3,
    OP_ADC  = 4'd4,
    OP_SBC  = 4'd5,
    OP_CMP  = 4'd6,
    OP_BIT  = 4'd7,
    OP_ASL  = 4'd8,
    OP_LSR  = 4'd9,
    OP_ROL  = 4'd10,
    OP_ROR  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13
  } ebalu_op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] reg_value;
    logic [DATA_W-1:0] operand;
    logic [DATA_W-1:0] status_in;
  } ebalu_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result;
    logic [DATA_W-1:0] status_out;
  } ebalu_rsp_t;

endpackage

/* rtl/core/eight_bit_alu_with_status_flags_core.sv */
// 8-bit ALU of the 6502 kind with C, Z, V and N flags. A request is taken on
// every cycle in which start is high (busy stays low), and its result appears
// on out_rsp with out_valid high for one cycle, after the request passes the
// input register and then the execute logic into the result register. One
// request per cycle is sustained indefinitely, and results must be captured
// when out_valid is high, as they cannot be held.
module eight_bit_alu_with_status_flags_core
  import ebalu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  ebalu_req_t in_req,
  output logic       out_valid,
  output ebalu_rsp_t out_rsp
);

  logic       req_valid_r;
  logic       req_valid_nxt;
  ebalu_req_t req_r;
  logic       rsp_valid_r;
  logic       rsp_valid_nxt;
  ebalu_rsp_t rsp_r;
  ebalu_rsp_t rsp_nxt;

  assign busy          = 1'b0;
  assign req_valid_nxt = start & ~busy;
  assign rsp_valid_nxt = req_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      rsp_valid_r <= rsp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid_nxt) begin
      req_r <= in_req;
    end
    if (rsp_valid_nxt) begin
      rsp_r <= rsp_nxt;
    end
  end

  ebalu_exec u_exec (
    .req (req_r),
    .rsp (rsp_nxt)
  );

  assign out_valid = rsp_valid_r;
  assign out_rsp   = rsp_r;

  // Every request taken out of reset yields exactly one result, through the input and result registers.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n, 2) && $past(rst_n)) |-> (out_valid == $past(start && !busy, 2)))
    else $error("result strobe does not follow request by two cycles");

  // Status bits 2 to 5 are never touched.
  a_passthru : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.status_out[5:2] == $past(in_req.status_in[5:2], 2)))
    else $error("status bits 2 to 5 changed");

  // Compare and bit test return the register byte unchanged.
  a_keep_reg : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_req.op, 2) == OP_CMP || $past(in_req.op, 2) == OP_BIT))
    |-> (out_rsp.result == $past(in_req.reg_value, 2)))
    else $error("compare or bit test altered the register byte");

endmodule

/* rtl/core/ebalu_exec.sv */
module ebalu_exec
  import ebalu_pkg::*;
(
  input  ebalu_req_t req,
  output ebalu_rsp_t rsp
);

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] m;
  logic [DATA_W-1:0] st;
  logic              c_old;
  logic [DATA_W-1:0] add_b;
  logic              add_cin;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] r;
  logic [DATA_W-1:0] st_nxt;
  logic              set_zn;
  logic              ovf;

  assign a     = req.reg_value;
  assign m     = req.operand;
  assign st    = req.status_in;
  assign c_old = st[FLAG_C_BIT];

  // One adder serves add, subtract and compare; subtract and compare use the
  // inverted operand, and compare always forces the carry in.
  always_comb begin
    add_b   = m;
    add_cin = c_old;
    case (req.op)
      OP_SBC: begin
        add_b = ~m;
      end
      OP_CMP: begin
        add_b   = ~m;
        add_cin = 1'b1;
      end
      default: begin
        add_b   = m;
        add_cin = c_old;
      end
    endcase
  end

  assign sum = {1'b0, a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
  assign ovf = ~(a[SIGN_BIT] ^ add_b[SIGN_BIT]) & (a[SIGN_BIT] ^ sum[SIGN_BIT]);

  always_comb begin
    r      = a;
    st_nxt = st;
    set_zn = 1'b1;
    unique case (req.op)
      OP_LOAD: r = m;
      OP_AND:  r = a & m;
      OP_OR:   r = a | m;
      OP_XOR:  r = a ^ m;
      OP_ADC, OP_SBC: begin
        r                  = sum[DATA_W-1:0];
        st_nxt[FLAG_C_BIT] = sum[DATA_W];
        st_nxt[FLAG_V_BIT] = ovf;
      end
      OP_CMP: begin
        set_zn             = 1'b0;
        st_nxt[FLAG_C_BIT] = sum[DATA_W];
        st_nxt[FLAG_Z_BIT] = (a == m);
        st_nxt[FLAG_N_BIT] = sum[SIGN_BIT];
      end
      OP_BIT: begin
        set_zn             = 1'b0;
        st_nxt[FLAG_N_BIT] = m[FLAG_N_BIT];
        st_nxt[FLAG_V_BIT] = m[FLAG_V_BIT];
        st_nxt[FLAG_Z_BIT] = ((a & m) == '0);
      end
      OP_ASL: begin
        r                  = {m[DATA_W-2:0], 1'b0};
        st_nxt[FLAG_C_BIT] = m[SIGN_BIT];
      end
      OP_LSR: begin
        r                  = {1'b0, m[DATA_W-1:1]};
        st_nxt[FLAG_C_BIT] = m[0];
      end
      OP_ROL: begin
        r                  = {m[DATA_W-2:0], c_old};
        st_nxt[FLAG_C_BIT] = m[SIGN_BIT];
      end
      OP_ROR: begin
        r                  = {c_old, m[DATA_W-1:1]};
        st_nxt[FLAG_C_BIT] = m[0];
      end
      OP_INC:  r = m + DATA_W'(1);
      OP_DEC:  r = m - DATA_W'(1);
      default: begin
        // Unused codes leave both bytes untouched.
        set_zn = 1'b0;
      end
    endcase
    if (set_zn) begin
      st_nxt[FLAG_Z_BIT] = (r == '0);
      st_nxt[FLAG_N_BIT] = r[SIGN_BIT];
    end
  end

  assign rsp.result     = r;
  assign rsp.status_out = st_nxt;

endmodule

/* dv/tb.sv */
module tb;
  import ebalu_pkg::*;

  // Codes outside the defined set; the block treats them as no operation.
  localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd14;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

  localparam int RAND_ITEMS  = 1350;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DIR_N       = 25;

  typedef struct packed {
    ebalu_req_t req;
    logic       fixed;
    ebalu_rsp_t rsp;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  ebalu_req_t in_req;
  logic       out_valid;
  ebalu_rsp_t out_rsp;

  ebalu_rsp_t rsp_next;
  ebalu_rsp_t rsp_due[$];
  int         mismatches;
  int         cycles;
  bit         no_gaps;

  // Rows with fixed set carry their expected response; the rest go through the predictor.
  dir_row_t dir_tab [DIR_N] = '{
    '{'{OP_LOAD, 8'h00, 8'h00, 8'h00}, 1'b1, '{8'h00, 8'h02}},
    '{'{OP_LOAD, 8'h00, 8'hFF, 8'h00}, 1'b1, '{8'hFF, 8'h80}},
    '{'{OP_LOAD, 8'h00, 8'h55, 8'hFF}, 1'b1, '{8'h55, 8'h7D}},
    '{'{OP_AND,  8'hFF, 8'h0F, 8'h00}, 1'b0, '{8'h00, 8'h00}},
    '{'{OP_OR,   8'hF0, 8'h0F, 8'h00}, 1'b1, '{8'hFF, 8'h80}},
    '{'{OP_XOR,  8'hFF, 8'hFF, 8'h00}, 1'b1, '{8'h00, 8'h02}},
    '{'{OP_ADC,  8'hFF, 8'h01, 8'h00}, 1'b1, '{8'h00, 8'h03}},
    '{'{OP_ADC,  8'h7F, 8'h01, 8'h00}, 1'b1, '{8'h80, 8'hC0}},
    '{'{OP_ADC,  8'hFF, 8'hFF, 8'h01}, 1'b1, '{8'hFF, 8'h81}},
    '{'{OP_ADC,  8'h80, 8'h80, 8'h00}, 1'b1, '{8'h00, 8'h43}},
    '{'{OP_SBC,  8'h00, 8'h01, 8'h01}, 1'b1, '{8'hFF, 8'h80}},
    '{'{OP_SBC,  8'h80, 8'h01, 8'h01}, 1'b1, '{8'h7F, 8'h41}},
    '{'{OP_SBC,  8'h00, 8'h00, 8'h00}, 1'b0, '{8'h00, 8'h00}},
    '{'{OP_CMP,  8'h10, 8'h10, 8'h00}, 1'b1, '{8'h10, 8'h03}},
    '{'{OP_CMP,  8'h00, 8'hFF, 8'hC0}, 1'b1, '{8'h00, 8'h40}},
    '{'{OP_BIT,  8'h00, 8'hC0, 8'h00}, 1'b1, '{8'h00, 8'hC2}},
    '{'{OP_BIT,  8'hFF, 8'h3F, 8'hC1}, 1'b1, '{8'hFF, 8'h01}},
    '{'{OP_ASL,  8'h00, 8'h80, 8'h00}, 1'b1, '{8'h00, 8'h03}},
    '{'{OP_LSR,  8'h00, 8'h01, 8'h00}, 1'b1, '{8'h00, 8'h03}},
    '{'{OP_ROL,  8'h00, 8'h80, 8'h01}, 1'b1, '{8'h01, 8'h01}},
    '{'{OP_ROR,  8'h00, 8'h01, 8'h01}, 1'b1, '{8'h80, 8'h81}},
    '{'{OP_INC,  8'h00, 8'hFF, 8'h00}, 1'b1, '{8'h00, 8'h02}},
    '{'{OP_DEC,  8'h00, 8'h00, 8'h00}, 1'b1, '{8'hFF, 8'h80}},
    '{'{OP_SPARE_LO, 8'h5A, 8'hA5, 8'h3C}, 1'b1, '{8'h5A, 8'h3C}},
    '{'{OP_SPARE_HI, 8'hA5, 8'h00, 8'hFF}, 1'b1, '{8'hA5, 8'hFF}}
  };

  eight_bit_alu_with_status_flags_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic ebalu_rsp_t alu_predict(ebalu_req_t r);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] mm;
    logic [DATA_W-1:0] st;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] diff;
    logic [DATA_W:0]   sum;
    logic              cin;
    logic              upd_zn;
    ebalu_rsp_t        p;
    a      = r.reg_value;
    m      = r.operand;
    st     = r.status_in;
    cin    = st[FLAG_C_BIT];
    res    = a;
    upd_zn = 1'b1;
    case (r.op)
      OP_LOAD: res = m;
      OP_AND:  res = a & m;
      OP_OR:   res = a | m;
      OP_XOR:  res = a ^ m;
      OP_ADC, OP_SBC: begin
        // Subtract is add of the inverted operand, so C set means no borrow.
        mm  = (r.op == OP_SBC) ? ~m : m;
        sum = {1'b0, a} + {1'b0, mm} + {{DATA_W{1'b0}}, cin};
        res = sum[DATA_W-1:0];
        st[FLAG_C_BIT] = sum[DATA_W];
        st[FLAG_V_BIT] = (a[SIGN_BIT] == mm[SIGN_BIT]) && (res[SIGN_BIT] != a[SIGN_BIT]);
      end
      OP_CMP: begin
        diff   = a - m;
        upd_zn = 1'b0;
        st[FLAG_C_BIT] = (a >= m);
        st[FLAG_Z_BIT] = (a == m);
        st[FLAG_N_BIT] = diff[SIGN_BIT];
      end
      OP_BIT: begin
        upd_zn = 1'b0;
        st[FLAG_N_BIT] = m[7];
        st[FLAG_V_BIT] = m[6];
        st[FLAG_Z_BIT] = ((a & m) == '0);
      end
      OP_ASL: begin
        st[FLAG_C_BIT] = m[SIGN_BIT];
        res = {m[DATA_W-2:0], 1'b0};
      end
      OP_LSR: begin
        st[FLAG_C_BIT] = m[0];
        res = {1'b0, m[DATA_W-1:1]};
      end
      OP_ROL: begin
        st[FLAG_C_BIT] = m[SIGN_BIT];
        res = {m[DATA_W-2:0], cin};
      end
      OP_ROR: begin
        st[FLAG_C_BIT] = m[0];
        res = {cin, m[DATA_W-1:1]};
      end
      OP_INC:  res = m + 8'd1;
      OP_DEC:  res = m - 8'd1;
      default: upd_zn = 1'b0;
    endcase
    if (upd_zn) begin
      st[FLAG_Z_BIT] = (res == '0);
      st[FLAG_N_BIT] = res[SIGN_BIT];
    end
    p.result     = res;
    p.status_out = st;
    return p;
  endfunction

  function automatic logic [DATA_W-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic flag_mismatch(string field, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %02h, expected %02h", cycles, field, got, want);
    mismatches++;
  endtask

  // Holds start low for the drawn gap, then presents the request until it is taken.
  task automatic issue(ebalu_req_t req, ebalu_rsp_t want);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    in_req   <= req;
    rsp_next <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** eight_bit_alu_with_status_flags_core: FAILED **");
      $finish;
    end
  end

  // Results are checked before the request taken at the same edge is queued.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (rsp_due.size() == 0) begin
          $display("unexpected response at cycle %0d: %02h %02h",
                   cycles, out_rsp.result, out_rsp.status_out);
          mismatches++;
        end else begin
          if (out_rsp.result !== rsp_due[0].result)
            flag_mismatch("result", out_rsp.result, rsp_due[0].result);
          if (out_rsp.status_out !== rsp_due[0].status_out)
            flag_mismatch("status_out", out_rsp.status_out, rsp_due[0].status_out);
          void'(rsp_due.pop_front());
        end
      end
      if (start && !busy) rsp_due.push_back(rsp_next);
    end
  end

  initial begin
    ebalu_req_t req;
    clk        = 1'b0;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_req     = '0;
    rsp_next   = '0;
    mismatches = 0;
    cycles     = 0;
    no_gaps    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      issue(dir_tab[i].req, dir_tab[i].fixed ? dir_tab[i].rsp : alu_predict(dir_tab[i].req));
    end
    drain();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      // Every 150 items, pick at random between back-to-back bursts and stretches with random gaps.
      if (i % 150 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (i == RAND_ITEMS / 2) drain();
      if ($urandom_range(0, 19) == 0)
        req.op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      else
        req.op = 4'($urandom_range(OP_LOAD, OP_DEC));
      req.reg_value = pick_byte();
      req.operand   = pick_byte();
      req.status_in = 8'($urandom_range(0, 255));
      issue(req, alu_predict(req));
    end
    drain();
    repeat (6) @(posedge clk);

    if (mismatches == 0) begin
      $display("** eight_bit_alu_with_status_flags_core: PASSED **");
    end else begin
      $display("** eight_bit_alu_with_status_flags_core: FAILED **");
    end
    $finish;
  end

endmodule
